@@ hdl/srpm_pkg.sv @@
// ----------------------------------------------------------------------------
// srpm_pkg : shared definitions for the stereo RMS / peak-hold level meter
// Field widths, register codes, sequencer states and the sample magnitude
// helper used by the meter and its divide / square-root engine.
// ----------------------------------------------------------------------------
`default_nettype none

package srpm_pkg;

   localparam int SAMPLE_W      = 24;
   localparam int LEVEL_W       = SAMPLE_W - 1;
   localparam int SUM_W         = 57;
   localparam int AGE_W         = 24;
   localparam int FACTOR_W      = 16;
   localparam int MUL_W         = 2 * LEVEL_W;
   localparam int CSR_DATA_W    = 24;
   localparam int CSR_INDEX_W   = 2;
   localparam int MAX_BLOCK_DEF = 1024;

   localparam logic [FACTOR_W-1:0] DISPLAY_DECAY_RST = FACTOR_W'(53740);
   localparam logic [FACTOR_W-1:0] HOLD_DECAY_RST    = FACTOR_W'(53740);
   localparam logic [AGE_W-1:0]    HOLD_SAMPLES_RST  = AGE_W'(48000);

   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_DECAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_DECAY    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_SAMPLES  = 2'd2;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FETCH  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQL,
      S_SQR,
      S_ACR,
      S_RTL,
      S_WTL,
      S_RTR,
      S_WTR,
      S_FDL,
      S_FHL,
      S_FDR,
      S_FHR,
      S_FEND,
      S_FOUT
   } meter_state_type;

   typedef enum logic [1:0] {
      RT_IDLE,
      RT_DIV,
      RT_SQRT,
      RT_DONE
   } root_phase_type;

   // Magnitude of a two's complement sample; negative full scale saturates.
   function automatic logic [LEVEL_W-1:0] sample_magnitude(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] neg;
      neg = ~s + SAMPLE_W'(1);
      if (!s[SAMPLE_W-1]) begin
         return s[LEVEL_W-1:0];
      end else if (s[SAMPLE_W-2:0] == '0) begin
         return '1;
      end else begin
         return neg[LEVEL_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

@@ hdl/srpm_divroot.sv @@
// ----------------------------------------------------------------------------
// srpm_divroot : iterative mean-square divider and integer square root
// One compare-and-subtract unit runs a restoring divide (one quotient bit
// per cycle) and then a digit-by-digit square root (one root bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module srpm_divroot import srpm_pkg::*; #(
   parameter int CNT_W = 11
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SUM_W-1:0]   dividend,
   input  wire logic [CNT_W-1:0]   divisor,
   output logic                    done,
   output logic [LEVEL_W-1:0]      root
);

   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int WORK_W = 2 * ROOT_W;
   localparam int CS_W   = (ROOT_W + 3 > CNT_W + 1) ? ROOT_W + 3 : CNT_W + 1;
   localparam int STEP_W = $clog2(WORK_W);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(WORK_W - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

   root_phase_type     phase_ff, phase_in;
   logic [WORK_W-1:0]  work_ff, work_in;
   logic [CS_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [CNT_W-1:0]   div_ff, div_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic [CS_W-1:0]    cs_a;
   logic [CS_W-1:0]    cs_b;
   logic [CS_W:0]      cs_diff;
   logic               cs_ge;

   // Shared compare-and-subtract unit.
   always_comb begin
      cs_a = '0;
      cs_b = '0;
      case (phase_ff)
         RT_DIV: begin
            cs_a = CS_W'({rem_ff[CNT_W-1:0], work_ff[WORK_W-1]});
            cs_b = CS_W'(div_ff);
         end
         RT_SQRT: begin
            cs_a = CS_W'({rem_ff[CS_W-3:0], work_ff[WORK_W-1 -: 2]});
            cs_b = CS_W'({root_ff, 2'b01});
         end
         default: begin
            cs_a = '0;
            cs_b = '0;
         end
      endcase
      cs_diff = {1'b0, cs_a} - {1'b0, cs_b};
      cs_ge   = ~cs_diff[CS_W];
   end

   always_comb begin
      phase_in = phase_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      case (phase_ff)
         RT_IDLE: begin
            if (start) begin
               work_in  = WORK_W'(dividend);
               rem_in   = '0;
               root_in  = '0;
               div_in   = divisor;
               step_in  = '0;
               phase_in = RT_DIV;
            end
         end
         RT_DIV: begin
            rem_in  = cs_ge ? cs_diff[CS_W-1:0] : cs_a;
            work_in = {work_ff[WORK_W-2:0], cs_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == DIV_LAST) begin
               // The quotient now fills the work register; the root starts afresh.
               rem_in   = '0;
               step_in  = '0;
               phase_in = RT_SQRT;
            end
         end
         RT_SQRT: begin
            rem_in  = cs_ge ? cs_diff[CS_W-1:0] : cs_a;
            work_in = {work_ff[WORK_W-3:0], 2'b00};
            root_in = {root_ff[ROOT_W-2:0], cs_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == ROOT_LAST) begin
               phase_in = RT_DONE;
            end
         end
         RT_DONE: begin
            phase_in = RT_IDLE;
         end
         default: begin
            phase_in = RT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RT_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
      step_ff <= step_in;
   end

   assign done = (phase_ff == RT_DONE);
   assign root = root_ff[LEVEL_W-1:0];

endmodule

`default_nettype wire

@@ hdl/stereo_rms_peak_hold_meter.sv @@
// ----------------------------------------------------------------------------
// stereo_rms_peak_hold_meter : stereo RMS and peak-hold level meter
// Accumulates per-channel sum of squares and peak magnitude over blocks,
// folds block RMS and peak into maxima, and reports decayed levels on fetch.
// ----------------------------------------------------------------------------
//
//   Port group | Role                     | Handshake
//   -----------+--------------------------+------------------------
//   req_*      | sample pairs and fetches | valid / ready, beat in
//   rsp_*      | levels, one per fetch    | valid / ready, beat out
//   csr_*      | decay and hold settings  | write enable, no wait
//
// A sample beat without a block close passes through S_SQL, S_SQR and
// S_ACR before the next beat can be taken. A close also runs the shared
// divide / square-root engine once per channel; that engine sets the worst
// case for a sample beat. A fetch steps through S_FDL to S_FEND, then waits
// in S_FOUT until the previous result beat has left the output register.
// Reset is synchronous and brings all levels to zero and the hold ages to
// expired. A result waiting on rsp does not stop sample beats from being
// accepted, but a further fetch then holds the request channel in S_FOUT.
`default_nettype none

module stereo_rms_peak_hold_meter import srpm_pkg::*; #(
   parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_command,
   input  wire logic [SAMPLE_W-1:0]    req_left_sample,
   input  wire logic [SAMPLE_W-1:0]    req_right_sample,
   input  wire logic                   req_stereo,
   input  wire logic                   req_last_sample,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [LEVEL_W-1:0]          rsp_rms_left,
   output logic [LEVEL_W-1:0]          rsp_rms_right,
   output logic [LEVEL_W-1:0]          rsp_peak_hold_left,
   output logic [LEVEL_W-1:0]          rsp_peak_hold_right,

   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // The block counter must hold MAX_BLOCK itself, since a block closes on
   // reaching it.
   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

   meter_state_type      state_ff, state_in;

   // Configuration registers.
   logic [FACTOR_W-1:0]  display_decay_ff, display_decay_in;
   logic [FACTOR_W-1:0]  hold_decay_ff, hold_decay_in;
   logic [AGE_W-1:0]     hold_samples_ff, hold_samples_in;

   // Latched sample beat.
   logic [LEVEL_W-1:0]   mag_left_ff, mag_left_in;
   logic [LEVEL_W-1:0]   mag_right_ff, mag_right_in;
   logic                 last_ff, last_in;

   // Meter state per channel.
   logic [SUM_W-1:0]     sum_left_ff, sum_left_in;
   logic [SUM_W-1:0]     sum_right_ff, sum_right_in;
   logic [CNT_W-1:0]     blk_count_ff, blk_count_in;
   logic [LEVEL_W-1:0]   run_peak_left_ff, run_peak_left_in;
   logic [LEVEL_W-1:0]   run_peak_right_ff, run_peak_right_in;
   logic [LEVEL_W-1:0]   max_rms_left_ff, max_rms_left_in;
   logic [LEVEL_W-1:0]   max_rms_right_ff, max_rms_right_in;
   logic [LEVEL_W-1:0]   max_peak_left_ff, max_peak_left_in;
   logic [LEVEL_W-1:0]   max_peak_right_ff, max_peak_right_in;
   logic [LEVEL_W-1:0]   shown_left_ff, shown_left_in;
   logic [LEVEL_W-1:0]   shown_right_ff, shown_right_in;
   logic [LEVEL_W-1:0]   hold_peak_left_ff, hold_peak_left_in;
   logic [LEVEL_W-1:0]   hold_peak_right_ff, hold_peak_right_in;
   logic [AGE_W-1:0]     hold_age_left_ff, hold_age_left_in;
   logic [AGE_W-1:0]     hold_age_right_ff, hold_age_right_in;

   // Shared multiplier with its product register.
   logic [LEVEL_W-1:0]   mul_a;
   logic [LEVEL_W-1:0]   mul_b;
   logic [MUL_W-1:0]     prod_ff, prod_in;
   logic [LEVEL_W-1:0]   decayed;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_rms_left_ff, rsp_rms_left_in;
   logic [LEVEL_W-1:0]   rsp_rms_right_ff, rsp_rms_right_in;
   logic [LEVEL_W-1:0]   rsp_hold_left_ff, rsp_hold_left_in;
   logic [LEVEL_W-1:0]   rsp_hold_right_ff, rsp_hold_right_in;

   // Divide / square-root engine.
   logic                 root_start;
   logic [SUM_W-1:0]     root_dividend;
   logic                 root_done;
   logic [LEVEL_W-1:0]   root_val;

   // Saturating add of one square into a running sum; the ceiling is all ones.
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                 input logic [MUL_W-1:0] sq);
      logic [SUM_W:0] t;
      t = {1'b0, sum} + (SUM_W + 1)'(sq);
      return t[SUM_W] ? '1 : t[SUM_W-1:0];
   endfunction

   function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] age);
      return (age == '1) ? age : age + AGE_W'(1);
   endfunction

   srpm_divroot #(
      .CNT_W (CNT_W)
   ) u_divroot (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .dividend (root_dividend),
      .divisor  (blk_count_ff),
      .done     (root_done),
      .root     (root_val)
   );

   // Multiplier operands follow the sequencer: squares while a sample is
   // taken in, decays while a fetch is worked through.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQL: begin
            mul_a = mag_left_ff;
            mul_b = mag_left_ff;
         end
         S_SQR: begin
            mul_a = mag_right_ff;
            mul_b = mag_right_ff;
         end
         S_FDL: begin
            mul_a = shown_left_ff;
            mul_b = LEVEL_W'(display_decay_ff);
         end
         S_FHL: begin
            mul_a = hold_peak_left_ff;
            mul_b = LEVEL_W'(hold_decay_ff);
         end
         S_FDR: begin
            mul_a = shown_right_ff;
            mul_b = LEVEL_W'(display_decay_ff);
         end
         S_FHR: begin
            mul_a = hold_peak_right_ff;
            mul_b = LEVEL_W'(hold_decay_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // A Q0.16 decay keeps the product bits above the fraction.
   assign decayed = prod_ff[FACTOR_W +: LEVEL_W];

   always_comb begin
      display_decay_in = display_decay_ff;
      hold_decay_in    = hold_decay_ff;
      hold_samples_in  = hold_samples_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_DISPLAY_DECAY: display_decay_in = csr_wdata[FACTOR_W-1:0];
            CSR_HOLD_DECAY:    hold_decay_in    = csr_wdata[FACTOR_W-1:0];
            CSR_HOLD_SAMPLES:  hold_samples_in  = csr_wdata[AGE_W-1:0];
            default:           display_decay_in = display_decay_ff;
         endcase
      end
   end

   // Sequencer: next state, meter state updates and the result register.
   always_comb begin
      state_in           = state_ff;
      mag_left_in        = mag_left_ff;
      mag_right_in       = mag_right_ff;
      last_in            = last_ff;
      sum_left_in        = sum_left_ff;
      sum_right_in       = sum_right_ff;
      blk_count_in       = blk_count_ff;
      run_peak_left_in   = run_peak_left_ff;
      run_peak_right_in  = run_peak_right_ff;
      max_rms_left_in    = max_rms_left_ff;
      max_rms_right_in   = max_rms_right_ff;
      max_peak_left_in   = max_peak_left_ff;
      max_peak_right_in  = max_peak_right_ff;
      shown_left_in      = shown_left_ff;
      shown_right_in     = shown_right_ff;
      hold_peak_left_in  = hold_peak_left_ff;
      hold_peak_right_in = hold_peak_right_ff;
      hold_age_left_in   = hold_age_left_ff;
      hold_age_right_in  = hold_age_right_ff;
      rsp_rms_left_in    = rsp_rms_left_ff;
      rsp_rms_right_in   = rsp_rms_right_ff;
      rsp_hold_left_in   = rsp_hold_left_ff;
      rsp_hold_right_in  = rsp_hold_right_ff;
      rsp_valid_in       = rsp_valid_ff & ~rsp_ready;
      root_start         = 1'b0;
      root_dividend      = sum_left_ff;
      req_ready          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mag_left_in  = sample_magnitude(req_left_sample);
               // In mono the right channel mirrors the left.
               mag_right_in = req_stereo ? sample_magnitude(req_right_sample)
                                         : sample_magnitude(req_left_sample);
               last_in      = req_last_sample;
               state_in     = (req_command == CMD_FETCH) ? S_FDL : S_SQL;
            end
         end
         S_SQL: begin
            state_in = S_SQR;
         end
         S_SQR: begin
            sum_left_in  = sat_add(sum_left_ff, prod_ff);
            blk_count_in = blk_count_ff + CNT_W'(1);
            state_in     = S_ACR;
         end
         S_ACR: begin
            sum_right_in = sat_add(sum_right_ff, prod_ff);
            if (mag_left_ff > run_peak_left_ff) begin
               run_peak_left_in = mag_left_ff;
            end
            if (mag_right_ff > run_peak_right_ff) begin
               run_peak_right_in = mag_right_ff;
            end
            hold_age_left_in  = age_step(hold_age_left_ff);
            hold_age_right_in = age_step(hold_age_right_ff);
            // The block closes on its marked last sample or when it is full.
            if (last_ff || blk_count_ff == MAX_CNT) begin
               state_in = S_RTL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RTL: begin
            root_start    = 1'b1;
            root_dividend = sum_left_ff;
            state_in      = S_WTL;
         end
         S_WTL: begin
            if (root_done) begin
               if (root_val > max_rms_left_ff) begin
                  max_rms_left_in = root_val;
               end
               state_in = S_RTR;
            end
         end
         S_RTR: begin
            root_start    = 1'b1;
            root_dividend = sum_right_ff;
            state_in      = S_WTR;
         end
         S_WTR: begin
            if (root_done) begin
               if (root_val > max_rms_right_ff) begin
                  max_rms_right_in = root_val;
               end
               if (run_peak_left_ff > max_peak_left_ff) begin
                  max_peak_left_in = run_peak_left_ff;
               end
               if (run_peak_right_ff > max_peak_right_ff) begin
                  max_peak_right_in = run_peak_right_ff;
               end
               sum_left_in       = '0;
               sum_right_in      = '0;
               run_peak_left_in  = '0;
               run_peak_right_in = '0;
               blk_count_in      = '0;
               state_in          = S_IDLE;
            end
         end
         S_FDL: begin
            state_in = S_FHL;
         end
         S_FHL: begin
            // The displayed level falls by the decay but never below the
            // loudest block since the previous fetch.
            shown_left_in = (max_rms_left_ff > decayed) ? max_rms_left_ff : decayed;
            state_in      = S_FDR;
         end
         S_FDR: begin
            if (max_peak_left_ff >= hold_peak_left_ff) begin
               hold_peak_left_in = max_peak_left_ff;
               hold_age_left_in  = '0;
            end else if (hold_age_left_ff >= hold_samples_ff) begin
               hold_peak_left_in = decayed;
            end
            state_in = S_FHR;
         end
         S_FHR: begin
            shown_right_in = (max_rms_right_ff > decayed) ? max_rms_right_ff : decayed;
            state_in       = S_FEND;
         end
         S_FEND: begin
            if (max_peak_right_ff >= hold_peak_right_ff) begin
               hold_peak_right_in = max_peak_right_ff;
               hold_age_right_in  = '0;
            end else if (hold_age_right_ff >= hold_samples_ff) begin
               hold_peak_right_in = decayed;
            end
            max_rms_left_in   = '0;
            max_rms_right_in  = '0;
            max_peak_left_in  = '0;
            max_peak_right_in = '0;
            state_in          = S_FOUT;
         end
         S_FOUT: begin
            // The result waits here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_rms_left_in   = shown_left_ff;
               rsp_rms_right_in  = shown_right_ff;
               rsp_hold_left_in  = hold_peak_left_ff;
               rsp_hold_right_in = hold_peak_right_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         display_decay_ff   <= DISPLAY_DECAY_RST;
         hold_decay_ff      <= HOLD_DECAY_RST;
         hold_samples_ff    <= HOLD_SAMPLES_RST;
         sum_left_ff        <= '0;
         sum_right_ff       <= '0;
         blk_count_ff       <= '0;
         run_peak_left_ff   <= '0;
         run_peak_right_ff  <= '0;
         max_rms_left_ff    <= '0;
         max_rms_right_ff   <= '0;
         max_peak_left_ff   <= '0;
         max_peak_right_ff  <= '0;
         shown_left_ff      <= '0;
         shown_right_ff     <= '0;
         hold_peak_left_ff  <= '0;
         hold_peak_right_ff <= '0;
         hold_age_left_ff   <= '1;
         hold_age_right_ff  <= '1;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         display_decay_ff   <= display_decay_in;
         hold_decay_ff      <= hold_decay_in;
         hold_samples_ff    <= hold_samples_in;
         sum_left_ff        <= sum_left_in;
         sum_right_ff       <= sum_right_in;
         blk_count_ff       <= blk_count_in;
         run_peak_left_ff   <= run_peak_left_in;
         run_peak_right_ff  <= run_peak_right_in;
         max_rms_left_ff    <= max_rms_left_in;
         max_rms_right_ff   <= max_rms_right_in;
         max_peak_left_ff   <= max_peak_left_in;
         max_peak_right_ff  <= max_peak_right_in;
         shown_left_ff      <= shown_left_in;
         shown_right_ff     <= shown_right_in;
         hold_peak_left_ff  <= hold_peak_left_in;
         hold_peak_right_ff <= hold_peak_right_in;
         hold_age_left_ff   <= hold_age_left_in;
         hold_age_right_ff  <= hold_age_right_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_left_ff       <= mag_left_in;
      mag_right_ff      <= mag_right_in;
      last_ff           <= last_in;
      prod_ff           <= prod_in;
      rsp_rms_left_ff   <= rsp_rms_left_in;
      rsp_rms_right_ff  <= rsp_rms_right_in;
      rsp_hold_left_ff  <= rsp_hold_left_in;
      rsp_hold_right_ff <= rsp_hold_right_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rms_left        = rsp_rms_left_ff;
   assign rsp_rms_right       = rsp_rms_right_ff;
   assign rsp_peak_hold_left  = rsp_hold_left_ff;
   assign rsp_peak_hold_right = rsp_hold_right_ff;

   // A full block is always closed before the next beat is taken.
   a_count_below_max : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> blk_count_ff != MAX_CNT)
      else $error("block counter left at its maximum while idle");

   // The engine only finishes while the sequencer waits for it.
   a_done_when_waiting : assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == S_WTL || state_ff == S_WTR))
      else $error("root engine finished outside a wait state");

   // A fetch result never overwrites a result beat still waiting.
   a_fetch_waits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FOUT && rsp_valid_ff && !rsp_ready) |=> state_ff == S_FOUT)
      else $error("fetch result loaded over a pending beat");

   // Taking a new peak restarts its hold time.
   a_hold_restart : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FDR && max_peak_left_ff >= hold_peak_left_ff)
      |=> hold_age_left_ff == '0)
      else $error("left hold age not cleared on a new peak");

endmodule

`default_nettype wire

@@ bench/stereo_rms_peak_hold_meter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_rms_peak_hold_meter_tb : self-checking bench for the level meter
// Streams sample and fetch beats into the meter through its request channel.
// Every accepted beat also drives a behavioural model of the meter held in
// this bench, and each fetch adds one expected set of levels. Response beats
// are checked field by field, in order, against those expectations. The run
// steps through several decay and hold settings between bursts of traffic.
// ----------------------------------------------------------------------------

module stereo_rms_peak_hold_meter_tb;
   import srpm_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 9;
   localparam int IDLE_PCT        = 10;
   // A block close runs the divide and square root once per channel. Settings
   // only change after a quiet wait of SETTLE_CYCLES, long enough for that.
   localparam int SETTLE_CYCLES   = 400;
   localparam int HOLD_OFF_CYCLES = 800;
   localparam int CYCLE_LIMIT     = 2000000;
   localparam int MAX_REPORTS     = 50;
   localparam int RANDOM_PHASES   = 10;
   localparam int PHASE_BEATS     = 21;
   localparam int STALL_FETCHES   = 6;
   localparam int STALL_PHASE     = 4;
   localparam int LONG_PHASE      = 6;
   localparam int LONG_BLOCK_LEN  = 1030;

   // The register map only uses three of the four index codes.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [SUM_W-1:0]       SUM_CEILING      = '1;
   localparam logic [AGE_W-1:0]       AGE_EXPIRED      = '1;

   typedef struct {
      logic                command;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                stereo;
      logic                last;
   } meter_beat_type;

   typedef struct {
      logic [LEVEL_W-1:0] rms_left;
      logic [LEVEL_W-1:0] rms_right;
      logic [LEVEL_W-1:0] peak_left;
      logic [LEVEL_W-1:0] peak_right;
   } meter_levels_type;

   // Clock, reset and the pins of the meter. Everything starts at a known
   // value so that nothing floats while reset is held.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_command = CMD_SAMPLE;
   logic [SAMPLE_W-1:0]    req_left_sample = '0;
   logic [SAMPLE_W-1:0]    req_right_sample = '0;
   logic                   req_stereo = 1'b0;
   logic                   req_last_sample = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]     rsp_rms_left;
   logic [LEVEL_W-1:0]     rsp_rms_right;
   logic [LEVEL_W-1:0]     rsp_peak_hold_left;
   logic [LEVEL_W-1:0]     rsp_peak_hold_right;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DISPLAY_DECAY;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Traffic bookkeeping. The initial block owns beats_issued, the driver
   // owns beats_accepted; the phase sequencer compares the two to know when
   // the meter has taken everything it was offered.
   meter_beat_type   beats_waiting[$];
   meter_beat_type   on_wire;
   meter_levels_type levels_due[$];
   int unsigned      beats_issued = 0;
   int unsigned      beats_accepted = 0;
   int unsigned      mismatches = 0;
   int unsigned      cycle_count = 0;
   int unsigned      hold_off_req = 0;
   int unsigned      hold_off_seen = 0;
   int unsigned      hold_off_left = 0;
   bit               calm = 1'b0;

   // Model of the meter: per channel accumulators, maxima since the last
   // fetch, the displayed levels and the peak-hold timers.
   logic [FACTOR_W-1:0] disp_factor;
   logic [FACTOR_W-1:0] hold_factor;
   logic [AGE_W-1:0]    hold_len;
   int unsigned         block_fill;
   logic [SUM_W-1:0]    sum_sq      [2];
   logic [LEVEL_W-1:0]  run_peak    [2];
   logic [LEVEL_W-1:0]  blk_rms_max [2];
   logic [LEVEL_W-1:0]  blk_peak_max[2];
   logic [LEVEL_W-1:0]  shown_rms   [2];
   logic [LEVEL_W-1:0]  held_peak   [2];
   logic [AGE_W-1:0]    held_age    [2];

   stereo_rms_peak_hold_meter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_left_sample     (req_left_sample),
      .req_right_sample    (req_right_sample),
      .req_stereo          (req_stereo),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_rms_left        (rsp_rms_left),
      .rsp_rms_right       (rsp_rms_right),
      .rsp_peak_hold_left  (rsp_peak_hold_left),
      .rsp_peak_hold_right (rsp_peak_hold_right),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // Level arithmetic
   // ------------------------------------------------------------------------

   // Magnitude of a signed sample. Negative full scale has no positive twin
   // in 23 bits, so it is clipped to the largest positive level.
   function automatic logic [LEVEL_W-1:0] level_of(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] flipped;
      flipped = -s;
      if (!s[SAMPLE_W-1]) begin
         return s[LEVEL_W-1:0];
      end
      if (flipped[SAMPLE_W-1]) begin
         return '1;
      end
      return flipped[LEVEL_W-1:0];
   endfunction

   // Floor square root, built up one result bit at a time. The mean square
   // is below 2^57, so the root fits comfortably in 30 bits.
   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] trial;
      int          b;
      r = '0;
      for (b = 29; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= x) begin
            r = trial;
         end
      end
      return r;
   endfunction

   // Multiply by a Q0.16 factor and drop the fraction.
   function automatic logic [LEVEL_W-1:0] scaled(input logic [LEVEL_W-1:0] v,
                                                 input logic [FACTOR_W-1:0] f);
      logic [LEVEL_W+FACTOR_W-1:0] product;
      product = v * f;
      return product[LEVEL_W+FACTOR_W-1:FACTOR_W];
   endfunction

   task automatic meter_model_reset();
      int c;
      disp_factor = DISPLAY_DECAY_RST;
      hold_factor = HOLD_DECAY_RST;
      hold_len    = HOLD_SAMPLES_RST;
      block_fill  = 0;
      for (c = 0; c < 2; c++) begin
         sum_sq[c]       = '0;
         run_peak[c]     = '0;
         blk_rms_max[c]  = '0;
         blk_peak_max[c] = '0;
         shown_rms[c]    = '0;
         held_peak[c]    = '0;
         held_age[c]     = AGE_EXPIRED;
      end
   endtask

   task automatic meter_model_csr(input logic [CSR_INDEX_W-1:0] index,
                                  input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_DISPLAY_DECAY: disp_factor = data[FACTOR_W-1:0];
         CSR_HOLD_DECAY:    hold_factor = data[FACTOR_W-1:0];
         CSR_HOLD_SAMPLES:  hold_len    = data[AGE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic add_to_block(input int c, input logic [LEVEL_W-1:0] mag);
      logic [63:0] total;
      total = 64'(sum_sq[c]) + 64'(mag) * 64'(mag);
      sum_sq[c] = (total > 64'(SUM_CEILING)) ? SUM_CEILING : total[SUM_W-1:0];
      if (mag > run_peak[c]) begin
         run_peak[c] = mag;
      end
      if (held_age[c] != AGE_EXPIRED) begin
         held_age[c] = held_age[c] + 1'b1;
      end
   endtask

   task automatic close_block(input int c);
      logic [63:0]        root;
      logic [LEVEL_W-1:0] rms;
      root = floor_root(64'(sum_sq[c]) / 64'(block_fill));
      rms  = root[LEVEL_W-1:0];
      if (rms > blk_rms_max[c]) begin
         blk_rms_max[c] = rms;
      end
      if (run_peak[c] > blk_peak_max[c]) begin
         blk_peak_max[c] = run_peak[c];
      end
      sum_sq[c]   = '0;
      run_peak[c] = '0;
   endtask

   // The displayed RMS falls away geometrically unless a louder block has
   // arrived. A fresh peak that matches or beats the held one restarts the
   // hold timer; otherwise the held peak only starts to fall once the timer
   // has run its course.
   task automatic fetch_channel(input int c);
      logic [LEVEL_W-1:0] faded;
      faded = scaled(shown_rms[c], disp_factor);
      shown_rms[c] = (blk_rms_max[c] > faded) ? blk_rms_max[c] : faded;
      if (blk_peak_max[c] >= held_peak[c]) begin
         held_peak[c] = blk_peak_max[c];
         held_age[c]  = '0;
      end else if (held_age[c] >= hold_len) begin
         held_peak[c] = scaled(held_peak[c], hold_factor);
      end
      blk_rms_max[c]  = '0;
      blk_peak_max[c] = '0;
   endtask

   task automatic meter_predict(input meter_beat_type b);
      meter_levels_type   lv;
      logic [LEVEL_W-1:0] mag_left;
      if (b.command == CMD_FETCH) begin
         fetch_channel(0);
         fetch_channel(1);
         lv.rms_left   = shown_rms[0];
         lv.rms_right  = shown_rms[1];
         lv.peak_left  = held_peak[0];
         lv.peak_right = held_peak[1];
         levels_due.push_back(lv);
      end else begin
         mag_left = level_of(b.left);
         add_to_block(0, mag_left);
         add_to_block(1, b.stereo ? level_of(b.right) : mag_left);
         block_fill++;
         // A marked last sample or a full block both close it.
         if (b.last || block_fill >= MAX_BLOCK_DEF) begin
            close_block(0);
            close_block(1);
            block_fill = 0;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Reporting
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string detail);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("[cycle %0d] mismatch: %s", cycle_count, detail);
      end
   endtask

   task automatic check_level(input string field, input logic [LEVEL_W-1:0] got,
                              input logic [LEVEL_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver: takes beats from the waiting queue, keeps valid and the
   // payload steady until the handshake, and feeds the model on acceptance.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            meter_predict(on_wire);
            beats_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (beats_waiting.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               on_wire = beats_waiting.pop_front();
               req_command      <= on_wire.command;
               req_left_sample  <= on_wire.left;
               req_right_sample <= on_wire.right;
               req_stereo       <= on_wire.stereo;
               req_last_sample  <= on_wire.last;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: checks each level beat against the oldest expectation
   // and throttles ready. A hold-off request from the sequencer keeps ready
   // low for a long count so that fetches back up into the meter.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      meter_levels_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (levels_due.size() == 0) begin
               report_mismatch($sformatf("level beat with nothing outstanding, rms %0d/%0d",
                                         rsp_rms_left, rsp_rms_right));
            end else begin
               want = levels_due.pop_front();
               check_level("rms_left", rsp_rms_left, want.rms_left);
               check_level("rms_right", rsp_rms_right, want.rms_right);
               check_level("peak_hold_left", rsp_peak_hold_left, want.peak_left);
               check_level("peak_hold_right", rsp_peak_hold_right, want.peak_right);
            end
         end
         if (hold_off_req != hold_off_seen) begin
            hold_off_seen = hold_off_req;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left != 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic push_beat(input logic cmd, input logic [SAMPLE_W-1:0] l,
                            input logic [SAMPLE_W-1:0] r, input logic st,
                            input logic last);
      meter_beat_type b;
      b.command = cmd;
      b.left    = l;
      b.right   = r;
      b.stereo  = st;
      b.last    = last;
      beats_waiting.push_back(b);
      beats_issued++;
   endtask

   // Fetch beats carry junk in the sample fields, which the meter must ignore.
   task automatic push_fetch();
      push_beat(CMD_FETCH, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom),
                1'($urandom));
   endtask

   // Random sample at a chosen loudness: the arithmetic shift keeps the sign
   // and pulls the magnitude down, so large shifts give quiet passages.
   function automatic logic [SAMPLE_W-1:0] random_sample(input int unsigned shift);
      logic [31:0] shifted;
      shifted = $signed($urandom) >>> shift;
      if ($urandom_range(0, 19) == 0) begin
         case ($urandom_range(0, 5))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'h800001;
            3:       return 24'hFFFFFF;
            4:       return 24'h000001;
            default: return 24'h000000;
         endcase
      end
      return shifted[SAMPLE_W-1:0];
   endfunction

   // Mostly well-formed blocks of random length and loudness with fetches in
   // between and now and then in the middle. Some blocks are left open on
   // purpose so that they run on into the next one.
   task automatic queue_random(input int unsigned beats, input int unsigned fetch_pct);
      int unsigned queued;
      int unsigned len;
      int unsigned shift;
      int unsigned i;
      bit          open_end;
      bit          silent;
      queued = 0;
      while (queued < beats) begin
         if ($urandom_range(0, 99) < fetch_pct) begin
            push_fetch();
            queued++;
         end else begin
            len      = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
                                                   : $urandom_range(1, 16);
            shift    = $urandom_range(0, 30);
            open_end = ($urandom_range(0, 9) == 0);
            silent   = ($urandom_range(0, 7) == 0);
            for (i = 0; i < len && queued < beats; i++) begin
               if ($urandom_range(0, 99) < 4) begin
                  push_fetch();
                  queued++;
               end
               push_beat(CMD_SAMPLE, silent ? '0 : random_sample(shift),
                         random_sample(shift), 1'($urandom),
                         (i == len - 1) && !open_end);
               queued++;
            end
         end
      end
   endtask

   // One block that never gets a last marker, so the meter has to close it
   // itself at the size limit; a few samples spill into a fresh block.
   task automatic queue_long_block();
      int unsigned i;
      for (i = 0; i < LONG_BLOCK_LEN; i++) begin
         push_beat(CMD_SAMPLE, random_sample($urandom_range(0, 3)),
                   random_sample($urandom_range(0, 3)), 1'($urandom), 1'b0);
      end
      push_fetch();
      push_beat(CMD_SAMPLE, random_sample(0), random_sample(0), 1'b1, 1'b1);
      push_fetch();
   endtask

   // Waits until every offered beat is taken and every result has come
   // back, then leaves time for a block close that produces no result.
   task automatic wait_for_quiet();
      do begin
         @(negedge clock);
      end while (beats_accepted != beats_issued || levels_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      meter_model_csr(index, data);
   endtask

   // Upper data bits of the 16-bit registers pass through as the caller gives
   // them, often set; the meter should keep only the low bits.
   task automatic program_meter(input logic [CSR_DATA_W-1:0] disp,
                                input logic [CSR_DATA_W-1:0] hold,
                                input logic [CSR_DATA_W-1:0] samples,
                                input bit poke_unused);
      csr_write(CSR_DISPLAY_DECAY, disp);
      csr_write(CSR_HOLD_DECAY, hold);
      csr_write(CSR_HOLD_SAMPLES, samples);
      if (poke_unused) begin
         csr_write(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom));
      end
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------

   initial begin
      int unsigned                phase;
      logic [CSR_DATA_W-1:0]      disp;
      logic [CSR_DATA_W-1:0]      hold;
      logic [CSR_DATA_W-1:0]      samples;

      meter_model_reset();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings. The first beats arrive while the hold timers are
      // still expired, and the first fetch comes with a block still open,
      // which must not show up in the levels.
      push_beat(CMD_SAMPLE, 24'h000000, 24'h7FFFFF, 1'b0, 1'b0);
      push_fetch();
      push_beat(CMD_SAMPLE, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0);
      push_beat(CMD_SAMPLE, 24'h800000, 24'h800001, 1'b1, 1'b0);
      push_beat(CMD_SAMPLE, 24'h800000, 24'h000000, 1'b0, 1'b0);
      push_beat(CMD_SAMPLE, 24'h000001, 24'hFFFFFF, 1'b1, 1'b1);
      push_fetch();
      push_fetch();
      push_beat(CMD_SAMPLE, 24'hFFFFFF, 24'h000001, 1'b1, 1'b1);
      push_fetch();
      push_beat(CMD_SAMPLE, 24'h400000, 24'hC00000, 1'b1, 1'b0);
      push_beat(CMD_SAMPLE, 24'h000000, 24'h000000, 1'b1, 1'b1);
      push_fetch();
      wait_for_quiet();

      // Zero factors and no hold time: levels collapse on the next fetch
      // that brings nothing new. The unused register index is written too.
      program_meter(24'hFF0000, 24'hAB0000, '0, 1'b1);
      push_beat(CMD_SAMPLE, 24'h7FFFFF, 24'h000000, 1'b0, 1'b1);
      push_fetch();
      push_fetch();
      push_beat(CMD_SAMPLE, 24'h123456, 24'hEDCBA9, 1'b1, 1'b1);
      push_fetch();
      push_fetch();
      wait_for_quiet();

      // Factors just under one and a two-sample hold: the peak is kept for
      // one fetch, then starts to fall by the smallest possible step.
      program_meter(24'h00FFFF, 24'h00FFFF, 24'd2, 1'b0);
      push_beat(CMD_SAMPLE, 24'h7FFFFF, 24'h800000, 1'b1, 1'b1);
      push_fetch();
      push_fetch();
      push_beat(CMD_SAMPLE, 24'h000000, 24'h000000, 1'b1, 1'b0);
      push_beat(CMD_SAMPLE, 24'h000000, 24'h000000, 1'b1, 1'b1);
      push_fetch();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_quiet();
         calm    = 1'b0;
         disp    = CSR_DATA_W'($urandom);
         hold    = CSR_DATA_W'($urandom);
         samples = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom)
                                                : CSR_DATA_W'($urandom_range(0, 48));
         case (phase)
            0: begin
               disp    = 24'h00FFFF;
               hold    = 24'h00FFFF;
               samples = '0;
            end
            1: begin
               disp = '0;
               hold = '0;
            end
            2: samples = 24'hFFFFFF;
            3: begin
               disp = '0;
               hold = 24'hFFFFFF;
            end
            default: ;
         endcase
         program_meter(disp, hold, samples, (phase % 3) == 0);

         if (phase == STALL_PHASE) begin
            // The receiver sits out a long stretch while fetches keep
            // coming, so the meter has to hold its input back.
            hold_off_req++;
            repeat (STALL_FETCHES) push_fetch();
            queue_random(PHASE_BEATS, 35);
         end else if (phase == LONG_PHASE) begin
            // No idling on either side for this whole phase.
            calm = 1'b1;
            queue_long_block();
         end else begin
            queue_random(PHASE_BEATS, 12);
         end
      end

      wait_for_quiet();
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/srpm_pkg.sv
hdl/srpm_divroot.sv
hdl/stereo_rms_peak_hold_meter.sv
bench/stereo_rms_peak_hold_meter_tb.sv
